[hw/rtl/psa_pkg.sv]
// shared types and constants of the process slot allocator
package psa_pkg;

  localparam int unsigned LOG2_SLOTS_DEF = 10;
  localparam int unsigned SLOT_W         = 10;
  localparam int unsigned IDENT_W        = 32;
  localparam int unsigned GEN_W          = 21;
  localparam int unsigned IN_TDATA_W     = 80;
  localparam int unsigned OUT_TDATA_W    = 48;

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_LOOKUP = 2'd2,
    CMD_RUN    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_OK     = 2'd0,
    ERR_BAD    = 2'd1,
    ERR_NOFREE = 2'd2
  } err_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    err_e               error_code;
    logic [SLOT_W-1:0]  slot;
    logic               slot_valid;
    logic [IDENT_W-1:0] ident;
    logic               yield_needed;
  } result_t;

endpackage

[hw/rtl/psa_tables.sv]
// slot and parent memories, one shared address per access, registered read data
module psa_tables import psa_pkg::*; #(
  parameter int unsigned LOG2_SLOTS = LOG2_SLOTS_DEF,
  parameter int unsigned SLOT_WORD_W = LOG2_SLOTS + IDENT_W + 1
) (
  input  logic                   clk_i,
  input  logic                   rd_en_i,
  input  logic [LOG2_SLOTS-1:0]  rd_addr_i,
  input  logic                   we_i,
  input  logic [LOG2_SLOTS-1:0]  wr_addr_i,
  input  logic [SLOT_WORD_W-1:0] wr_slot_i,
  input  logic [IDENT_W-1:0]     wr_parent_i,
  output logic [SLOT_WORD_W-1:0] rd_slot_o,
  output logic [IDENT_W-1:0]     rd_parent_o
);

  localparam int unsigned Depth = 1 << LOG2_SLOTS;

  logic [SLOT_WORD_W-1:0] slot_mem   [Depth];
  logic [IDENT_W-1:0]     parent_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      slot_mem[wr_addr_i]   <= wr_slot_i;
      parent_mem[wr_addr_i] <= wr_parent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_slot_o   <= slot_mem[rd_addr_i];
      rd_parent_o <= parent_mem[rd_addr_i];
    end
  end

endmodule

[hw/rtl/psa_engine.sv]
// command sequencer: read slot entry, check, write back, free list and current slot state
module psa_engine import psa_pkg::*; #(
  parameter int unsigned LOG2_SLOTS = LOG2_SLOTS_DEF,
  parameter int unsigned SLOT_WORD_W = LOG2_SLOTS + IDENT_W + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  cmd_e                   in_cmd_i,
  input  logic [SLOT_W-1:0]      in_slot_i,
  input  logic [IDENT_W-1:0]     in_ident_i,
  input  logic                   in_check_i,
  input  logic [IDENT_W-1:0]     in_parent_i,
  output logic                   in_ready_o,
  input  logic                   out_free_i,
  output logic                   commit_o,
  output result_t                result_o,
  output logic                   mem_rd_en_o,
  output logic [LOG2_SLOTS-1:0]  mem_rd_addr_o,
  output logic                   mem_we_o,
  output logic [LOG2_SLOTS-1:0]  mem_wr_addr_o,
  output logic [SLOT_WORD_W-1:0] mem_wr_slot_o,
  output logic [IDENT_W-1:0]     mem_wr_parent_o,
  input  logic [SLOT_WORD_W-1:0] mem_rd_slot_i,
  input  logic [IDENT_W-1:0]     mem_rd_parent_i
);

  localparam int unsigned IdxW = LOG2_SLOTS;
  localparam logic [IdxW:0] NumSlots = {1'b1, {IdxW{1'b0}}};
  localparam logic [IdxW:0] CntOne   = {{IdxW{1'b0}}, 1'b1};

  state_e state_q, state_d;

  // control state
  logic [IdxW-1:0]    head_q, head_d;
  logic [IdxW:0]      count_q, count_d;
  logic [IdxW:0]      wm_q, wm_d;
  logic [GEN_W-1:0]   gen_q, gen_d;
  logic [IdxW-1:0]    cur_q, cur_d;
  logic               cur_valid_q, cur_valid_d;
  logic [IDENT_W-1:0] cur_ident_q, cur_ident_d;

  // latched command word
  cmd_e               cmd_q;
  logic [IdxW-1:0]    addr_q;
  logic               oor_q;
  logic [IDENT_W-1:0] ident_q;
  logic               check_q;
  logic [IDENT_W-1:0] parent_q;

  logic               accept;
  logic               in_oor;
  logic [IdxW-1:0]    in_addr;

  logic               ent_fresh;
  logic               ent_used;
  logic [IdxW-1:0]    ent_next;
  logic [IDENT_W-1:0] ent_ident;
  logic [GEN_W-1:0]   gen_inc;
  logic [IDENT_W-1:0] new_id;
  logic               we;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit_o   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_EXEC: commit_o   = out_free_i;
      default: begin
        in_ready_o = 1'b0;
        commit_o   = 1'b0;
      end
    endcase
  end

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    in_oor = (IdxW < SLOT_W) && ((32'(in_slot_i) >> IdxW) != 32'd0);
    case (in_cmd_i)
      CMD_ALLOC:  in_addr = head_q;
      CMD_LOOKUP: in_addr = IdxW'(in_ident_i);
      default:    in_addr = IdxW'(in_slot_i);
    endcase
  end

  assign mem_rd_en_o   = accept;
  assign mem_rd_addr_o = in_addr;

  // entries at or above the high-water mark were never written and are read as their reset contents
  always_comb begin
    ent_fresh = ({1'b0, addr_q} >= wm_q);
    ent_used  = ent_fresh ? 1'b0 : mem_rd_slot_i[IdxW+IDENT_W];
    ent_next  = ent_fresh ? IdxW'(addr_q + IdxW'(1)) : mem_rd_slot_i[IdxW+IDENT_W-1:IDENT_W];
    ent_ident = ent_fresh ? IDENT_W'(addr_q) : mem_rd_slot_i[IDENT_W-1:0];
    gen_inc   = gen_q + GEN_W'(1);
    new_id    = IDENT_W'({gen_inc, 1'b0, addr_q});
  end

  always_comb begin
    result_o      = '0;
    we            = 1'b0;
    mem_wr_slot_o = {ent_used, ent_next, ent_ident};
    head_d        = head_q;
    count_d       = count_q;
    wm_d          = wm_q;
    gen_d         = gen_q;
    cur_d         = cur_q;
    cur_valid_d   = cur_valid_q;
    cur_ident_d   = cur_ident_q;
    case (cmd_q)
      CMD_ALLOC: begin
        if (count_q == '0) begin
          result_o.error_code = ERR_NOFREE;
        end else begin
          gen_d         = gen_inc;
          we            = 1'b1;
          mem_wr_slot_o = {1'b1, ent_next, new_id};
          head_d        = ent_next;
          count_d       = count_q - CntOne;
          if ({1'b0, addr_q} == wm_q) begin
            wm_d = wm_q + CntOne;
          end
          if (addr_q == cur_q) begin
            cur_ident_d = new_id;
          end
          result_o.slot       = SLOT_W'(addr_q);
          result_o.slot_valid = 1'b1;
          result_o.ident      = new_id;
        end
      end
      CMD_FREE: begin
        if (oor_q || !ent_used) begin
          result_o.error_code = ERR_BAD;
        end else begin
          we            = 1'b1;
          mem_wr_slot_o = {1'b0, head_q, ent_ident};
          head_d        = addr_q;
          count_d       = count_q + CntOne;
          if (cur_valid_q && (cur_q == addr_q)) begin
            cur_valid_d           = 1'b0;
            cur_d                 = '0;
            result_o.yield_needed = 1'b1;
          end
          result_o.slot       = SLOT_W'(addr_q);
          result_o.slot_valid = 1'b1;
          result_o.ident      = ent_ident;
        end
      end
      CMD_LOOKUP: begin
        if (ident_q == '0) begin
          // zero names the running slot, no checks
          if (cur_valid_q) begin
            result_o.slot       = SLOT_W'(cur_q);
            result_o.slot_valid = 1'b1;
            result_o.ident      = cur_ident_q;
          end
        end else if (!ent_used || (ent_ident != ident_q)) begin
          result_o.error_code = ERR_BAD;
        end else if (check_q && (!cur_valid_q ||
                     ((addr_q != cur_q) && (mem_rd_parent_i != cur_ident_q)))) begin
          result_o.error_code = ERR_BAD;
        end else begin
          result_o.slot       = SLOT_W'(addr_q);
          result_o.slot_valid = 1'b1;
          result_o.ident      = ent_ident;
        end
      end
      CMD_RUN: begin
        if (oor_q) begin
          result_o.error_code = ERR_BAD;
        end else begin
          cur_d               = addr_q;
          cur_valid_d         = 1'b1;
          cur_ident_d         = ent_ident;
          result_o.slot       = SLOT_W'(addr_q);
          result_o.slot_valid = 1'b1;
          result_o.ident      = ent_ident;
        end
      end
      default: result_o.error_code = ERR_BAD;
    endcase
  end

  assign mem_we_o        = we && commit_o;
  assign mem_wr_addr_o   = addr_q;
  assign mem_wr_parent_o = parent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      count_q     <= NumSlots;
      wm_q        <= '0;
      gen_q       <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      cur_ident_q <= '0;
    end else begin
      state_q <= state_d;
      if (commit_o) begin
        head_q      <= head_d;
        count_q     <= count_d;
        wm_q        <= wm_d;
        gen_q       <= gen_d;
        cur_q       <= cur_d;
        cur_valid_q <= cur_valid_d;
        cur_ident_q <= cur_ident_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= in_cmd_i;
      addr_q   <= in_addr;
      oor_q    <= in_oor;
      ident_q  <= in_ident_i;
      check_q  <= in_check_i;
      parent_q <= in_parent_i;
    end
  end

endmodule

[hw/rtl/process_slot_allocator.sv]
// top level of the process slot allocator: stream ports, output register, assertions

// Process slot table with a last-in first-out free list and generation-tagged
// 32-bit identifiers. Each input word is one command (allocate, free, lookup,
// make current) selected by s_axis_tuser_i, and each yields exactly one result
// word. The slot and parent memories are read when the word is accepted, and
// the registered entry is checked and written back in the execute state; the
// block takes no new word until the result of the last one is committed, and a
// held result delays the write back until the output register frees. No clearing
// pass is needed after reset: slots at or above a high-water mark read as their
// reset contents.
module process_slot_allocator import psa_pkg::*; #(
  parameter int unsigned LOG2_SLOTS = LOG2_SLOTS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // slot_in, ident_in, check_permission, parent_ident, zero pad
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // cmd
  input  logic [1:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // error_code, slot_out, slot_valid, ident_out, yield_needed, zero pad
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned SlotWordW = LOG2_SLOTS + IDENT_W + 1;

  logic                  eng_commit;
  result_t               eng_result;
  logic                  out_free;
  logic                  out_valid_q;
  result_t               out_q;

  logic                  rd_en;
  logic [LOG2_SLOTS-1:0] rd_addr;
  logic                  we;
  logic [LOG2_SLOTS-1:0] wr_addr;
  logic [SlotWordW-1:0]  wr_slot;
  logic [IDENT_W-1:0]    wr_parent;
  logic [SlotWordW-1:0]  rd_slot;
  logic [IDENT_W-1:0]    rd_parent;

  assign out_free = !out_valid_q || m_axis_tready_i;

  psa_engine #(
    .LOG2_SLOTS (LOG2_SLOTS)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid_i),
    .in_cmd_i        (cmd_e'(s_axis_tuser_i)),
    .in_slot_i       (s_axis_tdata_i[9:0]),
    .in_ident_i      (s_axis_tdata_i[41:10]),
    .in_check_i      (s_axis_tdata_i[42]),
    .in_parent_i     (s_axis_tdata_i[74:43]),
    .in_ready_o      (s_axis_tready_o),
    .out_free_i      (out_free),
    .commit_o        (eng_commit),
    .result_o        (eng_result),
    .mem_rd_en_o     (rd_en),
    .mem_rd_addr_o   (rd_addr),
    .mem_we_o        (we),
    .mem_wr_addr_o   (wr_addr),
    .mem_wr_slot_o   (wr_slot),
    .mem_wr_parent_o (wr_parent),
    .mem_rd_slot_i   (rd_slot),
    .mem_rd_parent_i (rd_parent)
  );

  psa_tables #(
    .LOG2_SLOTS (LOG2_SLOTS)
  ) u_tables (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .we_i        (we),
    .wr_addr_i   (wr_addr),
    .wr_slot_i   (wr_slot),
    .wr_parent_i (wr_parent),
    .rd_slot_o   (rd_slot),
    .rd_parent_o (rd_parent)
  );

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (eng_commit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (eng_commit) begin
      out_q <= eng_result;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.yield_needed, out_q.ident, out_q.slot_valid,
                            out_q.slot, out_q.error_code};

  // one word in flight: no new word straight after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("word accepted while previous command still executing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_commit |=> m_axis_tvalid_o)
    else $error("committed result not presented");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tdata_o[1:0] != ERR_OK)) |-> (m_axis_tdata_o[45:2] == '0))
    else $error("error result carries nonzero fields");

endmodule
